@@ hw/rtl/acwa_pkg.sv @@
// Package: shared types and constants for the address resolution cache.
package acwa_pkg;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DROP = 2'd1,
    CMD_LOOK = 2'd2,
    CMD_TICK = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_REFUSED  = 3'd4,
    ST_HIT      = 3'd5,
    ST_EXPIRED  = 3'd6,
    ST_TICKDONE = 3'd7
  } status_e;

  typedef enum logic [0:0] {
    CFG_TICK_PERIOD = 1'd0,
    CFG_PORT_AGING  = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FETCH,
    FSM_FINISH,
    FSM_AGE_READ,
    FSM_AGE_WRITE,
    FSM_OUT
  } fsm_e;

  localparam logic [7:0] TICK_RESET = 8'd60;

  // Slot payload kept in the memory.
  typedef struct packed {
    logic [31:0] ip;
    logic [4:0]  port;
    logic [55:0] hw;
    logic [55:0] via1;
    logic [55:0] via2;
    logic [3:0]  flags;
    logic [15:0] life;
  } entry_t;

  // Result item.
  typedef struct packed {
    logic        last;
    logic [15:0] timer;
    logic        kind;
    logic        publish;
    logic [1:0]  mode;
    logic [55:0] via2;
    logic [55:0] via1;
    logic [55:0] call;
    logic [4:0]  port;
    logic [31:0] addr;
    logic [2:0]  status;
  } result_t;

endpackage

@@ hw/rtl/acwa_store.sv @@
// Slot memory: one write port, one registered read port.
module acwa_store #(
  parameter int ENTRIES = 32
) (
  input  logic                                           clk_i,
  input  logic                                           we_i,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] waddr_i,
  input  acwa_pkg::entry_t                               wdata_i,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] raddr_i,
  output acwa_pkg::entry_t                               rdata_o
);
  import acwa_pkg::*;

  entry_t mem_q [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hw/rtl/arp_cache_with_aging_core.sv @@
// Top level: address resolution cache with time-to-live aging.
// Add, drop, lookup: one memory read per slot, then a read of the matching slot;
// the result is registered after the read of the matching slot.
// Tick: an aging pass (a read and a write-back per slot) only when the prescaler runs out,
// held by output stalls; the next transaction is accepted once the last result is taken.
// Reset (asynchronous, active low) empties the table via valid flops, sets the
// prescaler and tick period to 60 and enables aging on all ports.
module arp_cache_with_aging_core #(
  parameter int ENTRIES    = 32,
  parameter int PORT_CODES = 17
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: command[1:0], ip_address[33:2], port_code[38:34], hw_callsign[94:39],
  // via_first[150:95], via_second[206:151], link_mode[208:207], life_ticks[224:209],
  // publish[225], automatic_req[226], zero[231:227]
  input  logic [231:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[2:0], entry_address[34:3], entry_port[39:35], entry_callsign[95:40],
  // entry_via_first[151:96], entry_via_second[207:152], entry_mode[209:208],
  // entry_publish[210], hardware_kind[211], entry_timer[227:212], zero[231:228]
  output logic [231:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [16:0]  cfg_data_i
);
  import acwa_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NETROM = PORT_CODES - 1;

  fsm_e state_q, state_d;
  logic [ENTRIES-1:0] valid_q;
  logic [7:0]  period_q, presc_q;
  logic [16:0] aging_q;
  logic [231:0] req_q;
  logic [AW:0] idx_q;
  logic [AW-1:0] hit_q, free_q, cur_q;
  logic hit_v_q, free_v_q, pend_q;
  result_t res_q, res_d;
  logic out_v_q, res_load;

  logic [1:0]  r_cmd;
  logic [31:0] r_ip;
  logic [4:0]  r_port;
  logic        r_auto;
  assign r_cmd  = req_q[1:0];
  assign r_ip   = req_q[33:2];
  assign r_port = req_q[38:34];
  assign r_auto = req_q[226];

  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rdata;

  acwa_store #(.ENTRIES(ENTRIES)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic s_acc, last_idx, scan_done, cur_valid, key_eq, ages, expire, can_out;
  logic [15:0] life_dec;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == FSM_IDLE) && !out_v_q;
  assign cfg_ready_o   = 1'b1;
  assign can_out       = !out_v_q || m_axis_tready;
  assign raddr         = (state_q == FSM_FETCH) ? hit_q : idx_q[AW-1:0];
  assign last_idx      = (idx_q == (AW+1)'(ENTRIES - 1));
  assign scan_done     = (idx_q == (AW+1)'(ENTRIES));
  assign cur_valid     = valid_q[cur_q];
  assign key_eq        = cur_valid && rdata.ip == r_ip && rdata.port == r_port;
  assign ages          = (32'(rdata.port) < PORT_CODES) && (rdata.port < 5'd17) &&
                         aging_q[rdata.port];
  assign expire        = cur_valid && ages && rdata.life == 16'd1;
  assign life_dec      = rdata.life - 16'd1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (s_acc) begin
          if (s_axis_tdata[1:0] == CMD_TICK) begin
            state_d = (presc_q == 8'd1) ? FSM_AGE_READ : FSM_OUT;
          end else begin
            state_d = FSM_SCAN;
          end
        end
      end
      FSM_SCAN:      if (scan_done) state_d = FSM_FETCH;
      FSM_FETCH:     state_d = FSM_FINISH;
      FSM_FINISH:    state_d = FSM_IDLE;
      FSM_AGE_READ:  state_d = FSM_AGE_WRITE;
      FSM_AGE_WRITE: if (can_out) state_d = last_idx ? FSM_OUT : FSM_AGE_READ;
      FSM_OUT:       if (can_out) state_d = FSM_IDLE;
      default:       state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_q;
    wdata = rdata;
    if (state_q == FSM_FINISH && r_cmd == CMD_ADD && 32'(r_port) < PORT_CODES &&
        (hit_v_q || free_v_q)) begin
      we            = 1'b1;
      waddr         = hit_v_q ? hit_q : free_q;
      wdata.ip      = r_ip;
      wdata.port    = r_port;
      wdata.hw      = req_q[94:39];
      wdata.via1    = req_q[150:95];
      wdata.via2    = req_q[206:151];
      wdata.life    = req_q[224:209];
      wdata.flags   = {hit_v_q ? rdata.flags[3] : r_auto, req_q[225], req_q[208:207]};
    end else if (state_q == FSM_AGE_WRITE && can_out && cur_valid && ages &&
                 rdata.life != 16'd0) begin
      we         = 1'b1;
      wdata.life = life_dec;
    end
  end

  result_t fin;
  always_comb begin
    fin      = '0;
    fin.addr = r_ip;
    fin.port = r_port;
    fin.kind = (32'(r_port) == NETROM);
    fin.last = 1'b1;
    unique case (r_cmd)
      CMD_ADD: begin
        if (32'(r_port) >= PORT_CODES) fin.status = ST_REFUSED;
        else if (hit_v_q) fin.status = ST_UPDATED;
        else if (free_v_q) fin.status = ST_ADDED;
        else fin.status = ST_REFUSED;
      end
      CMD_DROP: begin
        if (!hit_v_q) fin.status = ST_NOTFOUND;
        else if (r_auto && !rdata.flags[3]) fin.status = ST_REFUSED;
        else fin.status = ST_DROPPED;
      end
      default: begin
        if (!hit_v_q) fin.status = ST_NOTFOUND;
        else begin
          fin.status  = ST_HIT;
          fin.call    = rdata.hw;
          fin.via1    = rdata.via1;
          fin.via2    = rdata.via2;
          fin.mode    = rdata.flags[1:0];
          fin.publish = rdata.flags[2];
          fin.timer   = rdata.life;
        end
      end
    endcase
  end

  always_comb begin
    res_load = 1'b0;
    res_d    = fin;
    unique case (state_q)
      FSM_FINISH: res_load = 1'b1;
      FSM_AGE_WRITE: begin
        if (can_out && expire) begin
          res_load     = 1'b1;
          res_d        = '0;
          res_d.status = ST_EXPIRED;
          res_d.addr   = rdata.ip;
          res_d.port   = rdata.port;
          res_d.kind   = (32'(rdata.port) == NETROM);
        end
      end
      FSM_OUT: begin
        if (can_out) begin
          res_load     = 1'b1;
          res_d        = '0;
          res_d.status = ST_TICKDONE;
          res_d.last   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      valid_q  <= '0;
      period_q <= TICK_RESET;
      presc_q  <= TICK_RESET;
      aging_q  <= '1;
      out_v_q  <= 1'b0;
      res_q    <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      hit_v_q  <= 1'b0;
      free_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_TICK_PERIOD) period_q <= cfg_data_i[7:0];
        else aging_q <= cfg_data_i;
      end
      if (res_load) begin
        res_q   <= res_d;
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        FSM_IDLE: begin
          idx_q    <= '0;
          pend_q   <= 1'b0;
          hit_v_q  <= 1'b0;
          free_v_q <= 1'b0;
          if (s_acc) begin
            req_q <= s_axis_tdata;
            if (s_axis_tdata[1:0] == CMD_TICK) begin
              presc_q <= (presc_q == 8'd1) ? period_q : presc_q - 8'd1;
            end
          end
        end
        FSM_SCAN: begin
          cur_q  <= raddr;
          pend_q <= 1'b1;
          idx_q  <= idx_q + 1'b1;
          if (pend_q) begin
            if (key_eq && !hit_v_q) begin
              hit_v_q <= 1'b1;
              hit_q   <= cur_q;
            end
            if (!cur_valid && !free_v_q) begin
              free_v_q <= 1'b1;
              free_q   <= cur_q;
            end
          end
        end
        FSM_FINISH: begin
          if (we) valid_q[waddr] <= 1'b1;
          if (r_cmd == CMD_DROP && fin.status == ST_DROPPED) valid_q[hit_q] <= 1'b0;
        end
        FSM_AGE_READ: cur_q <= raddr;
        FSM_AGE_WRITE: begin
          if (can_out) begin
            idx_q <= idx_q + 1'b1;
            if (expire) valid_q[cur_q] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {4'd0, res_q.timer, res_q.kind, res_q.publish, res_q.mode,
                          res_q.via2, res_q.via1, res_q.call, res_q.port, res_q.addr,
                          res_q.status};
endmodule

@@ hw/rtl/acwa_checker.sv @@
// Port checker for the address resolution cache, bound to the top level.
module acwa_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [231:0] m_axis_tdata,
  input logic         m_axis_tlast
);
  import acwa_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted while busy");
  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == ST_EXPIRED |-> !m_axis_tlast)
    else $error("expiry marked last");
  a_tick_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == ST_TICKDONE |-> m_axis_tlast)
    else $error("tick done not last");
endmodule

bind arp_cache_with_aging_core acwa_checker u_checker (.*);

@@ dv/arp_cache_with_aging_core_tb.sv @@
// Testbench for the address resolution cache: directed and random commands, scoreboard check.
module arp_cache_with_aging_core_tb;
  import acwa_pkg::*;

  localparam int NSLOT = 32;
  localparam int NETROM = 16;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] addr;
    logic [4:0]  port;
    logic [55:0] call;
    logic [55:0] via1;
    logic [55:0] via2;
    logic [1:0]  mode;
    logic        publish;
    logic        kind;
    logic [15:0] timer;
    logic        last;
  } resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [231:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [231:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [16:0] cfg_data_i = '0;

  arp_cache_with_aging_core dut (.*);

  always #2 clk_i = ~clk_i;

  // cache shadow
  logic [7:0]  period_q;
  logic [16:0] aging_q;
  logic [7:0]  presc_q;
  logic        sv_valid [NSLOT];
  logic [31:0] sv_ip [NSLOT];
  logic [4:0]  sv_port [NSLOT];
  logic [55:0] sv_hw [NSLOT];
  logic [55:0] sv_v1 [NSLOT];
  logic [55:0] sv_v2 [NSLOT];
  logic [3:0]  sv_flags [NSLOT];
  logic [15:0] sv_life [NSLOT];

  resp_t expected_q[$];
  int mismatches = 0;
  int send_idle = 34;
  int recv_idle = 79;
  // recently used keys for hits
  logic [31:0] known_ip[$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic resp_t mk(input logic [2:0] st, input logic [31:0] ip, input logic [4:0] p,
                               input int hit, input logic kind_ok, input logic lst);
    resp_t r;
    r = '{default: '0};
    r.status = st;
    r.addr = ip;
    r.port = p;
    if (hit >= 0) begin
      r.call = sv_hw[hit];
      r.via1 = sv_v1[hit];
      r.via2 = sv_v2[hit];
      r.mode = sv_flags[hit][1:0];
      r.publish = sv_flags[hit][2];
      r.timer = sv_life[hit];
    end
    r.kind = kind_ok && (p == NETROM);
    r.last = lst;
    return r;
  endfunction

  function automatic int lookup_slot(input logic [31:0] ip, input logic [4:0] p);
    for (int i = 0; i < NSLOT; i++)
      if (sv_valid[i] && sv_ip[i] == ip && sv_port[i] == p) return i;
    return -1;
  endfunction

  task automatic predict_cache(input logic [231:0] d);
    cmd_e c;
    logic [31:0] ip;
    logic [4:0] p;
    logic autom;
    int s;
    logic fresh;
    c = cmd_e'(d[1:0]);
    ip = d[33:2];
    p = d[38:34];
    autom = d[226];
    case (c)
      CMD_ADD: begin
        fresh = 1'b0;
        s = -1;
        if (p < 17) begin
          s = lookup_slot(ip, p);
          if (s < 0) begin
            for (int i = NSLOT - 1; i >= 0; i--) if (!sv_valid[i]) s = i;
            fresh = 1'b1;
          end
        end
        if (s < 0) begin
          expected_q.push_back(mk(ST_REFUSED, ip, p, -1, 1'b1, 1'b1));
        end else begin
          sv_valid[s] = 1'b1;
          sv_ip[s] = ip;
          sv_port[s] = p;
          sv_hw[s] = d[94:39];
          sv_v1[s] = d[150:95];
          sv_v2[s] = d[206:151];
          sv_life[s] = d[224:209];
          sv_flags[s] = {fresh ? autom : sv_flags[s][3], d[225], d[208:207]};
          expected_q.push_back(mk(fresh ? ST_ADDED : ST_UPDATED, ip, p, -1, 1'b1, 1'b1));
        end
      end
      CMD_DROP: begin
        s = lookup_slot(ip, p);
        if (s < 0) expected_q.push_back(mk(ST_NOTFOUND, ip, p, -1, 1'b1, 1'b1));
        else if (autom && !sv_flags[s][3])
          expected_q.push_back(mk(ST_REFUSED, ip, p, -1, 1'b1, 1'b1));
        else begin
          sv_valid[s] = 1'b0;
          expected_q.push_back(mk(ST_DROPPED, ip, p, -1, 1'b1, 1'b1));
        end
      end
      CMD_LOOK: begin
        s = lookup_slot(ip, p);
        if (s < 0) expected_q.push_back(mk(ST_NOTFOUND, ip, p, -1, 1'b1, 1'b1));
        else expected_q.push_back(mk(ST_HIT, ip, p, s, 1'b1, 1'b1));
      end
      default: begin
        presc_q = presc_q - 8'd1;
        if (presc_q == 0) begin
          presc_q = period_q;
          for (int i = 0; i < NSLOT; i++) begin
            if (sv_valid[i] && sv_port[i] < 17 && aging_q[sv_port[i]] && sv_life[i] != 0) begin
              sv_life[i] = sv_life[i] - 16'd1;
              if (sv_life[i] == 0) begin
                sv_valid[i] = 1'b0;
                expected_q.push_back(mk(ST_EXPIRED, sv_ip[i], sv_port[i], -1, 1'b1, 1'b0));
              end
            end
          end
        end
        expected_q.push_back(mk(ST_TICKDONE, '0, '0, -1, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic send_item(input logic [231:0] d);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk_i);
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_cache(d);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [231:0] pack_item(input cmd_e c, input logic [31:0] ip,
      input logic [4:0] p, input logic [55:0] hw, input logic [55:0] v1, input logic [55:0] v2,
      input logic [1:0] m, input logic [15:0] life, input logic pub, input logic autom);
    return {5'd0, autom, pub, life, m, v2, v1, hw, p, ip, c};
  endfunction

  function automatic logic [55:0] rnd56();
    return {$urandom, $urandom} & 56'hFFFFFFFFFFFFFF;
  endfunction

  task automatic send_cmd(input cmd_e c, input logic [31:0] ip, input logic [4:0] p,
                          input logic [15:0] life, input logic autom);
    send_item(pack_item(c, ip, p, rnd56(), rnd56(), rnd56(), 2'($urandom), life,
                        1'($urandom), autom));
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [16:0] v);
    cfg_index_i <= idx;
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_TICK_PERIOD) period_q = v[7:0];
    else aging_q = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    resp_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) report("unexpected result", m_axis_tdata[63:0], '0);
      else begin
        w = expected_q.pop_front();
        if (m_axis_tdata[2:0] != w.status) report("status", m_axis_tdata[2:0], w.status);
        if (m_axis_tdata[34:3] != w.addr) report("address", m_axis_tdata[34:3], w.addr);
        if (m_axis_tdata[39:35] != w.port) report("port", m_axis_tdata[39:35], w.port);
        if (m_axis_tdata[95:40] != w.call) report("callsign", m_axis_tdata[95:40], w.call);
        if (m_axis_tdata[151:96] != w.via1) report("via first", m_axis_tdata[151:96], w.via1);
        if (m_axis_tdata[207:152] != w.via2) report("via second", m_axis_tdata[207:152], w.via2);
        if (m_axis_tdata[209:208] != w.mode) report("mode", m_axis_tdata[209:208], w.mode);
        if (m_axis_tdata[210] != w.publish) report("publish", m_axis_tdata[210], w.publish);
        if (m_axis_tdata[211] != w.kind) report("kind", m_axis_tdata[211], w.kind);
        if (m_axis_tdata[227:212] != w.timer) report("timer", m_axis_tdata[227:212], w.timer);
        if (m_axis_tdata[231:228] != 4'd0) report("pad", m_axis_tdata[231:228], 0);
        if (m_axis_tlast != w.last) report("last", m_axis_tlast, w.last);
      end
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);

  task automatic test_directed();
    logic [55:0] ones;
    ones = '1;
    send_item(pack_item(CMD_ADD, 32'hFFFFFFFF, 5'd16, ones, ones, ones, 2'd3, 16'hFFFF, 1, 1));
    send_item(pack_item(CMD_ADD, 32'h0, 5'd0, '0, '0, '0, 2'd0, 16'd0, 0, 0));
    send_cmd(CMD_LOOK, 32'hFFFFFFFF, 5'd16, 0, 0);
    send_cmd(CMD_LOOK, 32'h0, 5'd0, 0, 0);
    send_cmd(CMD_ADD, 32'h0, 5'd0, 16'd1, 1);
    send_cmd(CMD_LOOK, 32'h0, 5'd0, 0, 0);
    send_cmd(CMD_DROP, 32'h0, 5'd0, 0, 1);
    send_cmd(CMD_ADD, 32'h1, 5'd31, 16'd1, 0);
    send_cmd(CMD_DROP, 32'h1, 5'd31, 0, 0);
    send_cmd(CMD_LOOK, 32'h1, 5'd17, 0, 0);
    send_cmd(CMD_DROP, 32'hFFFFFFFF, 5'd16, 0, 1);
    send_cmd(CMD_DROP, 32'hFFFFFFFF, 5'd16, 0, 0);
    send_cmd(CMD_DROP, 32'h0, 5'd0, 0, 0);
    send_cmd(CMD_LOOK, 32'h0, 5'd0, 0, 0);
    drain();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < NSLOT + 1; i++) send_cmd(CMD_ADD, 32'h100 + i, 5'(i % 17), 16'd2, 1);
    send_cmd(CMD_ADD, 32'h100, 5'd0, 16'd3, 0);
    drain();
  endtask

  task automatic test_aging();
    write_reg(CFG_TICK_PERIOD, 17'd1);
    write_reg(CFG_PORT_AGING, 17'h0AAAA);
    for (int i = 0; i < 62; i++) send_cmd(CMD_TICK, 0, 0, 0, 0);
    drain();
    write_reg(CFG_PORT_AGING, 17'h1FFFF);
    for (int i = 0; i < 4; i++) send_cmd(CMD_TICK, 0, 0, 0, 0);
    drain();
    write_reg(CFG_TICK_PERIOD, 17'd0);
    send_cmd(CMD_ADD, 32'h55, 5'd3, 16'd1, 0);
    for (int i = 0; i < 3; i++) send_cmd(CMD_TICK, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_random(input int n);
    int r;
    logic [31:0] ip;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (known_ip.size() == 0 || $urandom_range(3) == 0) begin
        ip = (r < 80) ? 32'($urandom_range(40)) : $urandom;
        known_ip.push_back(ip);
        if (known_ip.size() > 24) void'(known_ip.pop_front());
      end else ip = known_ip[$urandom_range(known_ip.size() - 1)];
      if (r < 40)
        send_cmd(CMD_ADD, ip, 5'($urandom_range(r < 2 ? 31 : 16)), 16'($urandom_range(5)),
                 1'($urandom));
      else if (r < 60) send_cmd(CMD_DROP, ip, 5'($urandom_range(16)), 0, 1'($urandom));
      else if (r < 80) send_cmd(CMD_LOOK, ip, 5'($urandom_range(17)), 0, 0);
      else send_cmd(CMD_TICK, 0, 0, 0, 0);
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    period_q = TICK_RESET;
    aging_q = '1;
    presc_q = TICK_RESET;
    for (int i = 0; i < NSLOT; i++) sv_valid[i] = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_table_full();
    test_aging();
    write_reg(CFG_TICK_PERIOD, 17'd255);
    write_reg(CFG_PORT_AGING, 17'h0);
    test_random(30);
    write_reg(CFG_TICK_PERIOD, 17'd2);
    write_reg(CFG_PORT_AGING, 17'h1FFFF);
    test_random(54);
    send_idle = 79;
    recv_idle = 34;
    write_reg(CFG_TICK_PERIOD, 17'd3);
    write_reg(CFG_PORT_AGING, 17'($urandom));
    test_random(54);
    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_TICK_PERIOD, 17'd1);
    test_random(54);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
